FILE: rtl/graph_store_dominating_set_test_unit_assert.svh
// Assertion macros for the graph store block.
// Overlapping implication, sampled on the rising clock edge.
`ifndef GRAPH_STORE_DOMINATING_SET_TEST_UNIT_ASSERT_SVH
`define GRAPH_STORE_DOMINATING_SET_TEST_UNIT_ASSERT_SVH

`define GSDS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gsds assertion failed");

// Next-cycle implication.
`define GSDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gsds assertion failed");

`endif

FILE: rtl/gsds_pkg.sv
`default_nettype none

package gsds_pkg;

   localparam int OP_W   = 2;
   localparam int VTX_W  = 4;
   localparam int SET_W  = 16;
   localparam int EDGE_W = 7;
   localparam int CSR_W  = 5;

   localparam logic [CSR_W-1:0] CSR_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_TEST   = 2'd3
   } op_type;

   typedef enum logic {
      ALU_MERGE  = 1'b0,
      ALU_TOGGLE = 1'b1
   } alu_fn_type;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [VTX_W-1:0] vertex_a;
      logic [VTX_W-1:0] vertex_b;
      logic [SET_W-1:0] member_set;
   } req_type;

   typedef struct packed {
      logic              edge_present;
      logic              is_dominating;
      logic [EDGE_W-1:0] edge_total;
      logic              error;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/gsds_if.sv
`default_nettype none

interface gsds_req_if;
   logic                          valid;
   logic                          ready;
   logic [gsds_pkg::OP_W-1:0]     operation;
   logic [gsds_pkg::VTX_W-1:0]    vertex_a;
   logic [gsds_pkg::VTX_W-1:0]    vertex_b;
   logic [gsds_pkg::SET_W-1:0]    member_set;

   modport source (output valid, output operation, output vertex_a, output vertex_b,
                   output member_set, input ready);
   modport sink   (input valid, input operation, input vertex_a, input vertex_b,
                   input member_set, output ready);
endinterface

interface gsds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          edge_present;
   logic                          is_dominating;
   logic [gsds_pkg::EDGE_W-1:0]   edge_total;
   logic                          error;

   modport source (output valid, output edge_present, output is_dominating,
                   output edge_total, output error, input ready);
   modport sink   (input valid, input edge_present, input is_dominating,
                   input edge_total, input error, output ready);
endinterface

interface gsds_csr_if;
   logic                          valid;
   logic                          ready;
   logic [gsds_pkg::CSR_W-1:0]    data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/graph_store_dominating_set_test_unit.sv
// Path from accept: an edge op with a bad index, or a set test that errors or runs with count 0,
//   goes straight to FIN; a query or an edge op that leaves the store as is reads row a in CHK;
//   an insert/remove that changes the store writes row a in CHK, row b in WRB; a set test scans
//   rows 0..count-1 in SCAN. Each result then waits in FIN for the response holding register.
// Throughput: one transaction at a time; req ready returns with the response, which a response stall delays.
// Reset (synchronous, active high): empty graph via row valid bits, edge count 0,
//   vertex_count 16; req ready is already high while reset is held.
`default_nettype none

`include "graph_store_dominating_set_test_unit_assert.svh"

module graph_store_dominating_set_test_unit #(
   parameter int MAX_VERTICES = 16
) (
   input  logic       clock,
   input  logic       reset,
   gsds_req_if.sink   req_ch,
   gsds_rsp_if.source rsp_ch,
   gsds_csr_if.sink   csr_ch
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   // vertex_count register; values above MAX_VERTICES act as MAX_VERTICES
   logic [gsds_pkg::CSR_W-1:0] vcount_ff;
   logic [CNT_W-1:0]           act_cnt;

   // response holding register: parts the core from the sink
   logic                       rsp_valid_ff, rsp_valid_in;
   gsds_pkg::rsp_type          rsp_data_ff;

   gsds_pkg::req_type          req;
   gsds_pkg::rsp_type          core_rsp;
   logic                       core_idle, core_done, take, req_accept;

   logic                       mem_wr_en;
   logic [IDX_W-1:0]           mem_wr_addr, mem_rd_addr;
   logic [MAX_VERTICES-1:0]    mem_wr_data, mem_rd_data;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= gsds_pkg::CSR_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         vcount_ff <= csr_ch.data;
      end
   end

   assign act_cnt = (32'(vcount_ff) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                      : CNT_W'(vcount_ff);

   assign req.operation  = req_ch.operation;
   assign req.vertex_a   = req_ch.vertex_a;
   assign req.vertex_b   = req_ch.vertex_b;
   assign req.member_set = req_ch.member_set;

   // new transaction only when the sequencer sits idle
   assign req_ch.ready = core_idle;
   assign req_accept   = req_ch.valid && req_ch.ready;

   gsds_core #(.MAX_VERTICES(MAX_VERTICES)) u_core (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .req         (req),
      .act_cnt     (act_cnt),
      .take        (take),
      .idle        (core_idle),
      .done        (core_done),
      .rsp         (core_rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   gsds_adj_mem #(.DEPTH(MAX_VERTICES), .WIDTH(MAX_VERTICES)) u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // finished result moves into the holding register when it is free or draining
   assign take         = core_done && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.edge_present  = rsp_data_ff.edge_present;
   assign rsp_ch.is_dominating = rsp_data_ff.is_dominating;
   assign rsp_ch.edge_total    = rsp_data_ff.edge_total;
   assign rsp_ch.error         = rsp_data_ff.error;

   // sequencer leaves idle on every accepted transaction
   `GSDS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_ch.ready)
   // a finished result waits in the core until the holding register frees up
   `GSDS_ASSERT_NEXT(a_done_held, clock, reset, core_done && !take, core_done)
   // errored transactions report no edge and no domination
   `GSDS_ASSERT_IMPL(a_error_flags, clock, reset, rsp_ch.valid && rsp_ch.error,
                     !rsp_ch.edge_present && !rsp_ch.is_dominating)

endmodule

`default_nettype wire

FILE: rtl/gsds_adj_mem.sv
`default_nettype none

// Adjacency row store: one write, one registered read per cycle.
// Rows never written read as zero (per-row valid bits cleared on reset).
module gsds_adj_mem #(
   parameter  int DEPTH = 16,
   parameter  int WIDTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] row_mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= row_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/gsds_row_alu.sv
`default_nettype none

// Shared row unit: bit toggle for edge updates, OR merge for coverage.
module gsds_row_alu #(
   parameter int WIDTH = 16
) (
   input  gsds_pkg::alu_fn_type fn,
   input  logic [WIDTH-1:0]     lhs,
   input  logic [WIDTH-1:0]     rhs,
   output logic [WIDTH-1:0]     res
);

   always_comb begin
      case (fn)
         gsds_pkg::ALU_TOGGLE: res = lhs ^ rhs;
         gsds_pkg::ALU_MERGE:  res = lhs | rhs;
         default:              res = lhs;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/gsds_core.sv
`default_nettype none

// Sequencer: edge op reads row a, may update a then b; test scans 0..count-1.
module gsds_core #(
   parameter  int MAX_VERTICES = 16,
   localparam int IDX_W = $clog2(MAX_VERTICES),
   localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  gsds_pkg::req_type       req,
   input  logic [CNT_W-1:0]        act_cnt,
   input  logic                    take,
   output logic                    idle,
   output logic                    done,
   output gsds_pkg::rsp_type       rsp,
   output logic                    mem_wr_en,
   output logic [IDX_W-1:0]        mem_wr_addr,
   output logic [MAX_VERTICES-1:0] mem_wr_data,
   output logic [IDX_W-1:0]        mem_rd_addr,
   input  logic [MAX_VERTICES-1:0] mem_rd_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CHK  = 5'b00010,
      ST_WRB  = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic [gsds_pkg::OP_W-1:0]      op_ff, op_in;
   logic [IDX_W-1:0]               a_ff, a_in;
   logic [IDX_W-1:0]               b_ff, b_in;
   logic [IDX_W-1:0]               v_ff, v_in;
   logic [MAX_VERTICES-1:0]        set_ff, set_in;
   logic [MAX_VERTICES-1:0]        covered_ff, covered_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [gsds_pkg::EDGE_W-1:0]    edges_ff, edges_in;
   logic                           present_ff, present_in;
   logic                           err_ff, err_in;

   gsds_pkg::alu_fn_type           alu_fn;
   logic [MAX_VERTICES-1:0]        alu_lhs, alu_rhs, alu_res;
   logic [MAX_VERTICES-1:0]        onehot_a, onehot_b, used;
   logic [gsds_pkg::SET_W-1:0]     used_in_set;
   logic                           edge_err, set_err, row_bit, change, last_row;

   gsds_row_alu #(.WIDTH(MAX_VERTICES)) u_alu (
      .fn  (alu_fn),
      .lhs (alu_lhs),
      .rhs (alu_rhs),
      .res (alu_res)
   );

   assign onehot_a = MAX_VERTICES'(1) << a_ff;
   assign onehot_b = MAX_VERTICES'(1) << b_ff;
   assign row_bit  = mem_rd_data[b_ff];
   assign last_row = (32'(v_ff) + 1) == 32'(cnt_ff);

   always_comb begin
      for (int i = 0; i < gsds_pkg::SET_W; i++) begin
         used_in_set[i] = i < 32'(act_cnt);
      end
      for (int i = 0; i < MAX_VERTICES; i++) begin
         used[i] = i < 32'(cnt_ff);
      end
   end

   assign edge_err = (32'(req.vertex_a) >= 32'(act_cnt)) ||
                     (32'(req.vertex_b) >= 32'(act_cnt));
   assign set_err  = |(req.member_set & ~used_in_set);

   // store changes only on a fresh insert (no self-loop) or a remove that hits
   assign change = ((op_ff == gsds_pkg::OP_INSERT) && !row_bit && (a_ff != b_ff)) ||
                   ((op_ff == gsds_pkg::OP_REMOVE) && row_bit);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      v_in        = v_ff;
      set_in      = set_ff;
      covered_in  = covered_ff;
      cnt_in      = cnt_ff;
      edges_in    = edges_ff;
      present_in  = present_ff;
      err_in      = err_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = a_ff;
      mem_rd_addr = '0;
      alu_fn      = gsds_pkg::ALU_TOGGLE;
      alu_lhs     = mem_rd_data;
      alu_rhs     = onehot_b;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = req.operation;
               a_in       = IDX_W'(req.vertex_a);
               b_in       = IDX_W'(req.vertex_b);
               set_in     = MAX_VERTICES'(req.member_set);
               covered_in = MAX_VERTICES'(req.member_set);
               cnt_in     = act_cnt;
               v_in       = '0;
               present_in = 1'b0;
               if (req.operation == gsds_pkg::OP_TEST) begin
                  err_in = set_err;
                  if (set_err || (act_cnt == '0)) begin
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  err_in      = edge_err;
                  mem_rd_addr = IDX_W'(req.vertex_a);
                  state_in    = edge_err ? ST_FIN : ST_CHK;
               end
            end
         end
         ST_CHK: begin
            present_in = row_bit;
            if (change) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = a_ff;
               mem_rd_addr = b_ff;
               if (op_ff == gsds_pkg::OP_INSERT) begin
                  edges_in = edges_ff + gsds_pkg::EDGE_W'(1);
               end else begin
                  edges_in = edges_ff - gsds_pkg::EDGE_W'(1);
               end
               state_in = ST_WRB;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_WRB: begin
            alu_rhs     = onehot_a;
            mem_wr_en   = 1'b1;
            mem_wr_addr = b_ff;
            state_in    = ST_FIN;
         end
         ST_SCAN: begin
            alu_fn     = gsds_pkg::ALU_MERGE;
            alu_lhs    = covered_ff;
            alu_rhs    = set_ff[v_ff] ? mem_rd_data : '0;
            covered_in = alu_res;
            if (last_row) begin
               state_in = ST_FIN;
            end else begin
               v_in        = v_ff + 1'b1;
               mem_rd_addr = v_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mem_wr_data = alu_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         edges_ff <= '0;
      end else begin
         state_ff <= state_in;
         edges_ff <= edges_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      v_ff       <= v_in;
      set_ff     <= set_in;
      covered_ff <= covered_in;
      cnt_ff     <= cnt_in;
      present_ff <= present_in;
      err_ff     <= err_in;
   end

   assign idle = state_ff == ST_IDLE;
   assign done = state_ff == ST_FIN;

   assign rsp.edge_present  = present_ff;
   assign rsp.is_dominating = !err_ff && (op_ff == gsds_pkg::OP_TEST) &&
                              ((covered_ff & used) == used);
   assign rsp.edge_total    = edges_ff;
   assign rsp.error         = err_ff;

endmodule

`default_nettype wire

FILE: tb/graph_store_dominating_set_test_unit_test.sv
`timescale 1ns / 100ps

module graph_store_dominating_set_test_unit_test;

   // Run-length timeout.
   localparam int CYCLE_LIMIT   = 400000;
   // Slack after the last response before a CSR write or the end of the run;
   // longer than the longest set test.
   localparam int SETTLE_CYCLES = 24;

   logic clock;
   logic reset;

   gsds_req_if req_ch ();
   gsds_rsp_if rsp_ch ();
   gsds_csr_if csr_ch ();

   graph_store_dominating_set_test_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the graph store: adjacency rows, edge count and the
   // vertex_count CSR as last written.
   // ------------------------------------------------------------------
   logic [gsds_pkg::SET_W-1:0]  adj_rows [16];
   logic [gsds_pkg::EDGE_W-1:0] edge_count;
   logic [gsds_pkg::CSR_W-1:0]  vertex_limit;

   gsds_pkg::req_type pending_req_q [$];    // transactions waiting for the driver
   gsds_pkg::rsp_type expected_rsp_q [$];   // predictions for accepted transactions
   bit                req_live;             // driver is presenting a transaction
   int                failures;
   int                cycles;

   initial begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      edge_count   = '0;
      vertex_limit = gsds_pkg::CSR_RESET;
      req_live     = 1'b0;
      failures     = 0;
      cycles       = 0;
   end

   // Advance the shadow store by one transaction and return its response.
   function automatic gsds_pkg::rsp_type graph_predict(gsds_pkg::req_type t);
      int unsigned                cnt;
      logic [gsds_pkg::SET_W:0]   used_wide;
      logic [gsds_pkg::SET_W-1:0] used;
      logic [gsds_pkg::SET_W-1:0] covered;
      gsds_pkg::rsp_type          r;
      // counts above the 16-vertex array act as 16
      cnt       = (vertex_limit > 5'd16) ? 16 : vertex_limit;
      used_wide = ({{gsds_pkg::SET_W{1'b0}}, 1'b1} << cnt) - 1'b1;
      used      = used_wide[gsds_pkg::SET_W-1:0];
      r         = '0;
      if (t.operation == gsds_pkg::OP_TEST) begin
         if ((t.member_set & ~used) != '0) begin
            r.error = 1'b1;
         end else begin
            // members cover themselves plus their neighbor rows
            covered = t.member_set;
            for (int v = 0; v < cnt; v++)
               if (t.member_set[v]) covered |= adj_rows[v];
            r.is_dominating = ((covered & used) == used);
         end
      end else if (t.vertex_a >= cnt || t.vertex_b >= cnt) begin
         r.error = 1'b1;
      end else begin
         r.edge_present = adj_rows[t.vertex_a][t.vertex_b];
         if (t.operation == gsds_pkg::OP_INSERT && !r.edge_present &&
             t.vertex_a != t.vertex_b) begin
            adj_rows[t.vertex_a][t.vertex_b] = 1'b1;
            adj_rows[t.vertex_b][t.vertex_a] = 1'b1;
            edge_count++;
         end else if (t.operation == gsds_pkg::OP_REMOVE && r.edge_present) begin
            adj_rows[t.vertex_a][t.vertex_b] = 1'b0;
            adj_rows[t.vertex_b][t.vertex_a] = 1'b0;
            edge_count--;
         end
      end
      r.edge_total = edge_count;
      return r;
   endfunction

   function automatic gsds_pkg::req_type graph_op(gsds_pkg::op_type op, int a, int b,
                                                   int set);
      gsds_pkg::req_type t;
      t.operation  = op;
      t.vertex_a   = a[gsds_pkg::VTX_W-1:0];
      t.vertex_b   = b[gsds_pkg::VTX_W-1:0];
      t.member_set = set[gsds_pkg::SET_W-1:0];
      return t;
   endfunction

   // Append one transaction to the driver's pending list.
   function automatic void queue_req(gsds_pkg::req_type t);
      pending_req_q = {pending_req_q, t};
   endfunction

   // Random transaction, mostly within the vertices in use so edges build up
   // and set tests see a real graph; the rest may hit the error path.
   function automatic gsds_pkg::req_type random_graph_op(int cnt);
      gsds_pkg::req_type          t;
      int                         eff;
      int                         pick;
      logic [gsds_pkg::SET_W:0]   used_wide;
      logic [gsds_pkg::SET_W-1:0] used;
      eff       = (cnt > 16) ? 16 : cnt;
      used_wide = ({{gsds_pkg::SET_W{1'b0}}, 1'b1} << eff) - 1'b1;
      used      = used_wide[gsds_pkg::SET_W-1:0];
      pick      = $urandom_range(0, 99);
      if (pick < 35)      t.operation = gsds_pkg::OP_INSERT;
      else if (pick < 50) t.operation = gsds_pkg::OP_REMOVE;
      else if (pick < 65) t.operation = gsds_pkg::OP_QUERY;
      else                t.operation = gsds_pkg::OP_TEST;
      if (eff > 0 && $urandom_range(0, 9) != 0) begin
         t.vertex_a = gsds_pkg::VTX_W'($urandom_range(0, eff - 1));
         t.vertex_b = gsds_pkg::VTX_W'($urandom_range(0, eff - 1));
      end else begin
         t.vertex_a = gsds_pkg::VTX_W'($urandom_range(0, 15));
         t.vertex_b = gsds_pkg::VTX_W'($urandom_range(0, 15));
      end
      case ($urandom_range(0, 9))
         0: t.member_set = gsds_pkg::SET_W'($urandom);      // may reach past the count
         1: t.member_set = used;                            // whole vertex set
         2, 3, 4: t.member_set = gsds_pkg::SET_W'($urandom & $urandom) & used; // sparse
         default: t.member_set = gsds_pkg::SET_W'($urandom) & used;
      endcase
      return t;
   endfunction

   // Block until the store is quiet: nothing queued, nothing presented,
   // nothing outstanding; then let the pipeline drain.
   task automatic wait_quiet();
      while (pending_req_q.size() != 0 || req_live || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // CSR write; only issued while quiet.
   task automatic set_vertex_count(int value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value[gsds_pkg::CSR_W-1:0];
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      vertex_limit = value[gsds_pkg::CSR_W-1:0];
   endtask

   // ------------------------------------------------------------------
   // Stimulus: directed checks of each corner, then random phases that
   // sweep vertex_count across its range, extremes included.
   // ------------------------------------------------------------------
   int phase_counts [12] = '{16, 1, 2, 31, 9, 16, 5, 0, 12, 17, 3, 16};

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.operation   = '0;
      req_ch.vertex_a    = '0;
      req_ch.vertex_b    = '0;
      req_ch.member_set  = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset count of 16: duplicates, self-loop, missing remove, empty / full sets
      queue_req(graph_op(gsds_pkg::OP_QUERY,  0, 15, 0));
      queue_req(graph_op(gsds_pkg::OP_INSERT, 0, 15, 0));
      queue_req(graph_op(gsds_pkg::OP_INSERT, 15, 0, 0));
      queue_req(graph_op(gsds_pkg::OP_QUERY,  15, 0, 0));
      queue_req(graph_op(gsds_pkg::OP_INSERT, 7, 7, 0));
      queue_req(graph_op(gsds_pkg::OP_QUERY,  7, 7, 0));
      queue_req(graph_op(gsds_pkg::OP_REMOVE, 3, 4, 0));
      queue_req(graph_op(gsds_pkg::OP_TEST,   0, 0, 16'h0000));
      queue_req(graph_op(gsds_pkg::OP_TEST,   0, 0, 16'hFFFF));
      queue_req(graph_op(gsds_pkg::OP_TEST,   0, 0, 16'h0001));
      queue_req(graph_op(gsds_pkg::OP_INSERT, 1, 2, 0));
      queue_req(graph_op(gsds_pkg::OP_INSERT, 3, 14, 0));
      queue_req(graph_op(gsds_pkg::OP_REMOVE, 0, 15, 0));
      queue_req(graph_op(gsds_pkg::OP_TEST,   15, 15, 16'h8000));
      wait_quiet();

      // count lowered to 4: edge 3-14 stays stored and counted
      set_vertex_count(4);
      queue_req(graph_op(gsds_pkg::OP_INSERT, 4, 0, 0));
      queue_req(graph_op(gsds_pkg::OP_QUERY,  3, 15, 0));
      queue_req(graph_op(gsds_pkg::OP_TEST,   0, 0, 16'h0010));
      queue_req(graph_op(gsds_pkg::OP_TEST,   0, 0, 16'h000F));
      queue_req(graph_op(gsds_pkg::OP_INSERT, 0, 1, 0));
      queue_req(graph_op(gsds_pkg::OP_INSERT, 2, 3, 0));
      queue_req(graph_op(gsds_pkg::OP_TEST,   0, 0, 16'h0009));
      queue_req(graph_op(gsds_pkg::OP_REMOVE, 1, 2, 0));
      wait_quiet();

      // count of zero: every edge op errors, empty set trivially dominates
      set_vertex_count(0);
      queue_req(graph_op(gsds_pkg::OP_INSERT, 0, 0, 0));
      queue_req(graph_op(gsds_pkg::OP_TEST,   0, 0, 16'h0000));
      queue_req(graph_op(gsds_pkg::OP_TEST,   0, 0, 16'h0001));
      wait_quiet();

      // all-ones count saturates at 16
      set_vertex_count(31);
      queue_req(graph_op(gsds_pkg::OP_INSERT, 15, 14, 0));
      queue_req(graph_op(gsds_pkg::OP_TEST,   0, 0, 16'hFFFF));
      wait_quiet();

      foreach (phase_counts[p]) begin
         set_vertex_count(phase_counts[p]);
         // phases with tiny counts are kept short
         repeat ((phase_counts[p] <= 1) ? 40 : 115)
            queue_req(random_graph_op(phase_counts[p]));
         wait_quiet();
      end

      if (failures == 0) begin
         $display("[graph_store_dominating_set_test_unit] OK");
      end else begin
         $display("[graph_store_dominating_set_test_unit] ERROR");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps between them.
   // The prediction is taken at the accepting edge, so the shadow store
   // advances in transaction order.
   // ------------------------------------------------------------------
   gsds_pkg::req_type shown_req;
   int                burst_left = 0;
   int                gap_left   = 0;

   always @(posedge clock) begin
      bit                next_valid;
      gsds_pkg::req_type next_req;
      gsds_pkg::rsp_type predicted;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_live     = 1'b0;
      end else begin
         next_valid = req_ch.valid;
         next_req   = shown_req;
         if (req_ch.valid && req_ch.ready) begin
            predicted      = graph_predict(shown_req);
            expected_rsp_q = {expected_rsp_q, predicted};
            next_valid     = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_req_q.size() != 0) begin
               next_req   = pending_req_q.pop_front();
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst; a quarter of them follow on with no gap at all
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
         req_ch.valid      <= next_valid;
         req_ch.operation  <= next_req.operation;
         req_ch.vertex_a   <= next_req.vertex_a;
         req_ch.vertex_b   <= next_req.vertex_b;
         req_ch.member_set <= next_req.member_set;
         shown_req = next_req;
         req_live  = next_valid;
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: ready follows a rotating stall pattern that is
   // re-picked whenever pattern_age wraps (sometimes all-ready, sometimes stall heavy).
   // ------------------------------------------------------------------
   logic [15:0] stall_pattern = 16'hFFFF;
   int          pattern_age   = 0;

   always @(posedge clock) begin
      gsds_pkg::rsp_type got;
      gsds_pkg::rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.edge_present  = rsp_ch.edge_present;
            got.is_dominating = rsp_ch.is_dominating;
            got.edge_total    = rsp_ch.edge_total;
            got.error         = rsp_ch.error;
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response with nothing outstanding: %s=%0b dom=%0b %s=%0d err=%0b",
                        $time, "present", got.edge_present, got.is_dominating, "total",
                        got.edge_total, got.error);
               failures++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.edge_present !== want.edge_present) begin
                  $display("%0t: edge_present expected %0b actual %0b",
                           $time, want.edge_present, got.edge_present);
                  failures++;
               end
               if (got.is_dominating !== want.is_dominating) begin
                  $display("%0t: is_dominating expected %0b actual %0b",
                           $time, want.is_dominating, got.is_dominating);
                  failures++;
               end
               if (got.edge_total !== want.edge_total) begin
                  $display("%0t: edge_total expected %0d actual %0d",
                           $time, want.edge_total, got.edge_total);
                  failures++;
               end
               if (got.error !== want.error) begin
                  $display("%0t: error expected %0b actual %0b",
                           $time, want.error, got.error);
                  failures++;
               end
            end
         end
         rsp_ch.ready <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         pattern_age++;
         if (pattern_age == 48) begin
            pattern_age = 0;
            case ($urandom_range(0, 3))
               0: stall_pattern = 16'hFFFF;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'($urandom | $urandom);
               default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
            endcase
            if (stall_pattern == '0) stall_pattern = 16'h0001;
         end
      end
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[graph_store_dominating_set_test_unit] ERROR");
         $finish;
      end
   end

endmodule

FILE: graph_store_dominating_set_test_unit.f
+incdir+rtl
rtl/gsds_pkg.sv
rtl/gsds_if.sv
rtl/gsds_adj_mem.sv
rtl/gsds_row_alu.sv
rtl/gsds_core.sv
rtl/graph_store_dominating_set_test_unit.sv
tb/graph_store_dominating_set_test_unit_test.sv
